[rtl/core/plwo_pkg.sv]
// plwo_pkg: constants and word types shared by the log pipeline
// no dependencies; used by every module of pixel_log_with_offset
package plwo_pkg;

  localparam int OFFSET_BITS = 48;
  localparam int LOGQ_BITS   = 24;
  localparam int MANT_BITS   = 31;
  localparam int LOG2_FRAC   = 30;
  localparam int LN2_FRAC    = 40;
  localparam int E_W         = 8;

  localparam logic [39:0] LN2_Q40 = 40'hB1_7217_F7D2;
  localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;

  typedef struct packed {
    logic                  vld;
    logic                  nonpos;
    logic signed [E_W-1:0] e;
  } ctl_t;

  typedef struct packed {
    logic [MANT_BITS:0]   m;
    logic [LOG2_FRAC-1:0] frac;
  } mant_t;

endpackage

[rtl/core/plwo_front.sv]
// plwo_front: offset add, leading-one search and mantissa normalization, four stages
// depends on plwo_pkg
module plwo_front #(
  parameter int PIXEL_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        en,
  input  logic                                        in_vld,
  input  logic [PIXEL_BITS-1:0]                       pixel,
  input  logic signed [plwo_pkg::OFFSET_BITS-1:0]     offset,
  output plwo_pkg::ctl_t                              ctl_o,
  output plwo_pkg::mant_t                             mant_o
);

  localparam int OB     = plwo_pkg::OFFSET_BITS;
  localparam int MB     = plwo_pkg::MANT_BITS;
  localparam int EW     = plwo_pkg::E_W;
  localparam int SUM_W  = ((PIXEL_BITS + FRAC_BITS > OB) ? PIXEL_BITS + FRAC_BITS : OB) + 1;
  localparam int NGRP   = (SUM_W + 7) / 8;
  localparam int NGRP_W = $clog2(NGRP);
  localparam int SPAD_W = NGRP * 8;
  localparam int KK_W   = NGRP_W + 3;

  // stage 1: sum
  logic [SUM_W-1:0] sum_nxt;
  logic             np_nxt;
  logic             v1_r, np1_r;
  logic [SUM_W-1:0] s1_r;

  // stage 2: per-group leading one
  logic [SPAD_W-1:0] sp;
  logic [NGRP-1:0]   any_nxt;
  logic [2:0]        pos_nxt [NGRP];
  logic              v2_r, np2_r;
  logic [SUM_W-1:0]  s2_r;
  logic [NGRP-1:0]   any2_r;
  logic [2:0]        pos2_r [NGRP];

  // stage 3: leading-one position
  logic [NGRP_W-1:0] grp;
  logic [KK_W-1:0]   k_nxt;
  logic              v3_r, np3_r;
  logic [SUM_W-1:0]  s3_r;
  logic [KK_W-1:0]   k3_r;

  // stage 4: normalize
  logic [KK_W-1:0]  shl, shr;
  logic [SUM_W-1:0] s_shr;
  logic [MB:0]      m_nxt;
  plwo_pkg::ctl_t   ctl_nxt, ctl_r;
  plwo_pkg::mant_t  mant_r;

  assign sum_nxt = ({{(SUM_W-PIXEL_BITS){pixel[PIXEL_BITS-1]}}, pixel} << FRAC_BITS)
                 + {{(SUM_W-OB){offset[OB-1]}}, offset};
  assign np_nxt  = sum_nxt[SUM_W-1] | (sum_nxt == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r  <= sum_nxt;
      np1_r <= np_nxt;
    end
  end

  assign sp = SPAD_W'(s1_r);

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      any_nxt[g] = |sp[g*8 +: 8];
      pos_nxt[g] = 3'd0;
      for (int b = 0; b < 8; b++) begin
        if (sp[g*8 + b]) begin
          pos_nxt[g] = 3'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      np2_r  <= np1_r;
      s2_r   <= s1_r;
      any2_r <= any_nxt;
      pos2_r <= pos_nxt;
    end
  end

  always_comb begin
    grp = '0;
    for (int g = 0; g < NGRP; g++) begin
      if (any2_r[g]) begin
        grp = NGRP_W'(g);
      end
    end
    k_nxt = {grp, pos2_r[grp]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      np3_r <= np2_r;
      s3_r  <= s2_r;
      k3_r  <= k_nxt;
    end
  end

  assign shl   = KK_W'(MB) - k3_r;
  assign shr   = k3_r - KK_W'(MB);
  assign s_shr = s3_r >> shr;

  always_comb begin
    if (k3_r <= KK_W'(MB)) begin
      m_nxt = s3_r[MB:0] << shl;
    end else begin
      m_nxt = s_shr[MB:0];
    end
    ctl_nxt.vld    = v3_r;
    ctl_nxt.nonpos = np3_r;
    ctl_nxt.e      = EW'(k3_r) - EW'(FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.vld <= 1'b0;
    end else if (en) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mant_r.m    <= m_nxt;
      mant_r.frac <= '0;
    end
  end

  assign ctl_o  = ctl_r;
  assign mant_o = mant_r;

endmodule

[rtl/core/plwo_sq_stage.sv]
// plwo_sq_stage: one squaring step of the bit-serial log2, one fraction bit per stage
// depends on plwo_pkg
module plwo_sq_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  plwo_pkg::ctl_t  ctl_i,
  input  plwo_pkg::mant_t mant_i,
  output plwo_pkg::ctl_t  ctl_o,
  output plwo_pkg::mant_t mant_o
);

  localparam int MB   = plwo_pkg::MANT_BITS;
  localparam int LF   = plwo_pkg::LOG2_FRAC;
  localparam int SQ_W = 2 * MB + 2;

  logic [SQ_W-1:0] sq, sq_rnd;
  logic [MB+1:0]   t;
  logic            up;
  plwo_pkg::mant_t mant_nxt;
  plwo_pkg::ctl_t  ctl_r;
  plwo_pkg::mant_t mant_r;

  assign sq     = SQ_W'(mant_i.m) * SQ_W'(mant_i.m);
  assign sq_rnd = sq + (SQ_W'(1) << (MB - 1));
  assign t      = sq_rnd[SQ_W-1:MB];
  assign up     = t[MB+1];

  always_comb begin
    mant_nxt.m    = up ? t[MB+1:1] : t[MB:0];
    mant_nxt.frac = {mant_i.frac[LF-2:0], up};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.vld <= 1'b0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mant_r <= mant_nxt;
    end
  end

  assign ctl_o  = ctl_r;
  assign mant_o = mant_r;

endmodule

[rtl/core/plwo_back.sv]
// plwo_back: scaling by ln 2, rounding, saturation and the output register
// depends on plwo_pkg
module plwo_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  plwo_pkg::ctl_t                      ctl_i,
  input  plwo_pkg::mant_t                     mant_i,
  output logic                                out_vld,
  output logic [plwo_pkg::LOGQ_BITS-1:0]      log_q,
  output logic                                non_positive
);

  localparam int EW    = plwo_pkg::E_W;
  localparam int LF    = plwo_pkg::LOG2_FRAC;
  localparam int LQ    = plwo_pkg::LOGQ_BITS;
  localparam int PE_W  = EW + 41;
  localparam int PF_W  = plwo_pkg::LN2_FRAC;
  localparam int PP_W  = LF + 32;
  localparam int ACC_W = PE_W + 2;
  localparam int SH    = plwo_pkg::LN2_FRAC - FRAC_BITS;

  localparam logic signed [ACC_W-1:0] RND = {{(ACC_W-1){1'b0}}, 1'b1} << (SH - 1);
  localparam logic signed [ACC_W-1:0] HI  = {{(ACC_W-LQ+1){1'b0}}, {(LQ-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] LO  = -HI;

  logic signed [PE_W-1:0]  pe_nxt, pe_r;
  logic [PP_W-1:0]         pf_full;
  logic [PF_W-1:0]         pf_r;
  plwo_pkg::ctl_t          ctl_r;
  logic signed [ACC_W-1:0] acc, res, sat;
  logic [LQ-1:0]           log_nxt, log_r;
  logic                    vld_r, np_r;

  assign pe_nxt  = ctl_i.e * $signed({1'b0, plwo_pkg::LN2_Q40});
  assign pf_full = PP_W'(mant_i.frac) * PP_W'(plwo_pkg::LN2_Q32);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.vld <= 1'b0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pe_r <= pe_nxt;
      pf_r <= pf_full[PP_W-1 -: PF_W];
    end
  end

  assign acc = {{(ACC_W-PE_W){pe_r[PE_W-1]}}, pe_r}
             + {{(ACC_W-PF_W){1'b0}}, pf_r} + RND;
  assign res = acc >>> SH;

  always_comb begin
    if (res > HI) begin
      sat = HI;
    end else if (res < LO) begin
      sat = LO;
    end else begin
      sat = res;
    end
    if (ctl_r.nonpos) begin
      log_nxt = {1'b1, {(LQ-1){1'b0}}};
    end else begin
      log_nxt = sat[LQ-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= ctl_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      log_r <= log_nxt;
      np_r  <= ctl_r.nonpos;
    end
  end

  assign out_vld      = vld_r;
  assign log_q        = log_r;
  assign non_positive = np_r;

endmodule

[rtl/core/pixel_log_with_offset.sv]
// pixel_log_with_offset: ln(pixel + offset) in fixed point, fully pipelined
// depends on plwo_pkg, plwo_front, plwo_sq_stage, plwo_back
//
//  channel  direction  handshake              word
//  in       input      in_valid / in_stall    in_pixel
//  out      output     out_valid / out_stall  out_log_q, out_non_positive
//  cfg      input      cfg_valid / cfg_ready  cfg_offset_q
//
// one pixel per clock unless out_stall holds the pipeline; stages: 4 front stages, one stage per
// log2 fraction bit (30 squaring multipliers), 2 scaling stages ending in the output register
// synchronous active-low reset clears valid bits and the offset register
// the whole pipeline holds while a result waits and out_stall is high; in_stall follows it
// cfg_ready is always high
module pixel_log_with_offset #(
  parameter int PIXEL_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [PIXEL_BITS-1:0]            in_pixel,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [plwo_pkg::LOGQ_BITS-1:0]   out_log_q,
  output logic                                    out_non_positive,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic signed [plwo_pkg::OFFSET_BITS-1:0] cfg_offset_q
);

  localparam int NSQ = plwo_pkg::LOG2_FRAC;

  logic                                    en;
  logic signed [plwo_pkg::OFFSET_BITS-1:0] offset_r;
  plwo_pkg::ctl_t                          ctl_s  [NSQ+1];
  plwo_pkg::mant_t                         mant_s [NSQ+1];
  logic [plwo_pkg::LOGQ_BITS-1:0]          log_q;

  assign cfg_ready = 1'b1;
  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      offset_r <= cfg_offset_q;
    end
  end

  plwo_front #(
    .PIXEL_BITS (PIXEL_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_valid),
    .pixel  (in_pixel),
    .offset (offset_r),
    .ctl_o  (ctl_s[0]),
    .mant_o (mant_s[0])
  );

  for (genvar i = 0; i < NSQ; i++) begin : g_sq
    plwo_sq_stage u_sq (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .ctl_i  (ctl_s[i]),
      .mant_i (mant_s[i]),
      .ctl_o  (ctl_s[i+1]),
      .mant_o (mant_s[i+1])
    );
  end

  plwo_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .ctl_i        (ctl_s[NSQ]),
    .mant_i       (mant_s[NSQ]),
    .out_vld      (out_valid),
    .log_q        (log_q),
    .non_positive (out_non_positive)
  );

  assign out_log_q = log_q;

endmodule

[rtl/core/plwo_checker.sv]
// plwo_checker: port-level checks for pixel_log_with_offset, bound to the top level
// depends on plwo_pkg
module plwo_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [plwo_pkg::LOGQ_BITS-1:0]     out_log_q,
  input logic                               out_non_positive
);

  localparam logic [plwo_pkg::LOGQ_BITS-1:0] BAD_CODE =
    {1'b1, {(plwo_pkg::LOGQ_BITS-1){1'b0}}};

  a_bad_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_non_positive |-> out_log_q == BAD_CODE)
    else $error("non-positive word without the invalid code");

  a_good_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_non_positive |-> out_log_q != BAD_CODE)
    else $error("valid log word carries the invalid code");

  a_back_press: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not track a held output word");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_log_q) && $stable(out_non_positive))
    else $error("stalled output word changed");

  a_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid)
    else $error("output word valid right after reset");

endmodule

bind pixel_log_with_offset plwo_checker u_plwo_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_log_q        (out_log_q),
  .out_non_positive (out_non_positive)
);

[sim/pixel_log_with_offset_tb.sv]
// pixel_log_with_offset_tb: self-checking bench for the fixed-point ln(pixel + offset) pipeline
// depends on plwo_pkg and pixel_log_with_offset; predicts every result word internally
// and compares it, allowing 1 LSB on valid logs
module pixel_log_with_offset_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LOGQ_BITS   = plwo_pkg::LOGQ_BITS;
  localparam int OFFSET_BITS = plwo_pkg::OFFSET_BITS;
  localparam int MANT_BITS   = plwo_pkg::MANT_BITS;
  localparam int LOG2_FRAC   = plwo_pkg::LOG2_FRAC;
  localparam int LN2_FRAC    = plwo_pkg::LN2_FRAC;
  localparam logic [39:0] LN2_Q40 = plwo_pkg::LN2_Q40;
  localparam logic [31:0] LN2_Q32 = plwo_pkg::LN2_Q32;

  localparam int PIX_W = 32;
  localparam int FRAC = 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;
  localparam logic signed [LOGQ_BITS-1:0] INVALID_CODE = {1'b1, {(LOGQ_BITS-1){1'b0}}};
  localparam longint LOG_MAX = (longint'(1) << (LOGQ_BITS - 1)) - 1;
  localparam logic signed [OFFSET_BITS-1:0] OFS_MAX = {1'b0, {(OFFSET_BITS-1){1'b1}}};
  localparam logic signed [OFFSET_BITS-1:0] OFS_MIN = {1'b1, {(OFFSET_BITS-1){1'b0}}};

  typedef struct packed {
    logic signed [LOGQ_BITS-1:0] log_q;
    logic                        non_positive;
  } log_word_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [PIX_W-1:0]              in_pixel;
  logic                          out_valid;
  logic                          out_stall;
  logic signed [LOGQ_BITS-1:0]   out_log_q;
  logic                          out_non_positive;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic signed [OFFSET_BITS-1:0] cfg_offset_q;

  log_word_t                     pending_logs[$];
  logic signed [OFFSET_BITS-1:0] offset_model;
  int errors;
  int cycles;
  int pixels_sent;
  int offset_writes;
  int invalid_sums;
  int in_held_cycles;
  int hold_req;
  int burst_left;
  bit no_gaps;

  pixel_log_with_offset #(
    .PIXEL_BITS(PIX_W),
    .FRAC_BITS (FRAC)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pixel        (in_pixel),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_log_q       (out_log_q),
    .out_non_positive(out_non_positive),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_offset_q    (cfg_offset_q)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words pending", cycles, pending_logs.size());
      $display("status: fail");
      $finish;
    end
  end

  function automatic log_word_t predict_log(logic [PIX_W-1:0] pix,
                                            logic signed [OFFSET_BITS-1:0] ofs);
    longint          sum;
    longint unsigned s;
    longint unsigned m;
    longint unsigned frac;
    longint          acc;
    longint          e;
    longint          r;
    int              k;
    log_word_t       w;
    sum = longint'($signed(pix)) * (longint'(1) << FRAC) + longint'(ofs);
    if (sum <= 0) begin
      w.log_q = INVALID_CODE;
      w.non_positive = 1'b1;
      return w;
    end
    s = sum;
    k = 0;
    for (int i = 0; i < 63; i++)
      if (s[i]) k = i;
    if (k <= MANT_BITS) m = s << (MANT_BITS - k);
    else m = s >> (k - MANT_BITS);
    frac = 0;
    for (int i = 0; i < LOG2_FRAC; i++) begin
      m = (m * m + (64'd1 << (MANT_BITS - 1))) >> MANT_BITS;
      frac = frac << 1;
      if (m >= (64'd1 << (MANT_BITS + 1))) begin
        frac = frac | 64'd1;
        m = m >> 1;
      end
    end
    e = longint'(k) - FRAC;
    acc = e * longint'(LN2_Q40)
        + longint'((frac * longint'(LN2_Q32)) >> (LOG2_FRAC + 32 - LN2_FRAC));
    acc = acc + (longint'(1) << (LN2_FRAC - FRAC - 1));
    r = acc >>> (LN2_FRAC - FRAC);
    if (r > LOG_MAX) r = LOG_MAX;
    if (r < -LOG_MAX) r = -LOG_MAX;
    w.log_q = r[LOGQ_BITS-1:0];
    w.non_positive = 1'b0;
    return w;
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  task automatic check_word(input logic signed [LOGQ_BITS-1:0] got_log, input logic got_flag);
    log_word_t want;
    longint    diff;
    if (pending_logs.size() == 0) begin
      report_mismatch($sformatf("unexpected word log_q=%0d flag=%0b", got_log, got_flag));
      return;
    end
    want = pending_logs.pop_front();
    if (want.non_positive) invalid_sums++;
    if (got_flag !== want.non_positive)
      report_mismatch($sformatf("non_positive %0b, want %0b", got_flag, want.non_positive));
    diff = longint'(got_log) - longint'(want.log_q);
    if (want.non_positive || got_log === INVALID_CODE) begin
      if (got_log !== want.log_q)
        report_mismatch($sformatf("log_q %0d, want %0d", got_log, want.log_q));
    end else if ($isunknown(got_log) || diff > 1 || diff < -1) begin
      report_mismatch($sformatf("log_q %0d, want %0d", got_log, want.log_q));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_word(out_log_q, out_non_positive);
    if (rst_n && in_valid && in_stall) in_held_cycles++;
  end

  // receiver: random stalls, quiet stretches, and a long hold on request
  int hold_left;
  int stall_left;
  int calm_left;
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (calm_left > 0) begin
      out_stall <= 1'b0;
      calm_left--;
    end else begin
      out_stall <= 1'b0;
      case ($urandom_range(0, 99)) inside
        [0:7]:   calm_left = $urandom_range(20, 80);
        [8:27]:  stall_left = $urandom_range(1, 3);
        [28:31]: stall_left = $urandom_range(10, 40);
        default: ;
      endcase
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      burst_left = $urandom_range(30, 100);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 9);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= pix;
    do @(posedge clk); while (in_stall);
    pending_logs.push_back(predict_log(pix, offset_model));
    pixels_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_logs.size() != 0) @(posedge clk);
  endtask

  task automatic write_offset(input logic signed [OFFSET_BITS-1:0] ofs);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_offset_q <= ofs;
    do @(posedge clk); while (!cfg_ready);
    offset_model = ofs;
    offset_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [PIX_W-1:0] rand_pixel(logic signed [OFFSET_BITS-1:0] ofs);
    int          r;
    logic [7:0]  b;
    logic [15:0] h;
    longint      near;
    r = $urandom_range(0, 99);
    b = 8'($urandom);
    h = 16'($urandom);
    if (r < 30) return $urandom;
    if (r < 50) return $urandom_range(0, 300);
    if (r < 55) return {24'd0, b};
    if (r < 60) return {{24{b[7]}}, b};
    if (r < 65) return {16'd0, h};
    if (r < 70) return {{16{h[15]}}, h};
    if (r < 85) begin
      // around the point where the sum crosses zero
      near = -(longint'(ofs) >>> FRAC) + longint'($urandom_range(0, 6)) - 3;
      return near[PIX_W-1:0];
    end
    near = (longint'(1) << $urandom_range(0, 30)) + longint'($urandom_range(0, 2)) - 1;
    return near[PIX_W-1:0];
  endfunction

  task automatic test_directed_pixels();
    logic [PIX_W-1:0] list[$];
    list = {32'd1, 32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd2, 32'd3,
            32'h0000_00FF, 32'hFFFF_FF80, 32'h0000_7FFF, 32'hFFFF_8000, 32'h0000_8000,
            32'h0000_FFFF};
    foreach (list[i]) send_pixel(list[i]);
  endtask

  task automatic test_directed_offsets();
    write_offset(48'sd1);
    send_pixel(32'd0);
    send_pixel(32'd5);
    write_offset(-48'sd65536);
    send_pixel(32'd1);
    send_pixel(32'd2);
    write_offset(OFS_MAX);
    send_pixel(32'h7FFF_FFFF);
    send_pixel(32'h8000_0000);
    write_offset(OFS_MIN);
    send_pixel(32'h7FFF_FFFF);
    send_pixel(32'h8000_0000);
  endtask

  task automatic test_random_offsets();
    logic signed [OFFSET_BITS-1:0] ofs;
    logic [63:0]                   wide;
    for (int phase = 0; phase < 8; phase++) begin
      wide = {$urandom, $urandom};
      case (phase)
        0: ofs = '0;
        1: ofs = OFFSET_BITS'($urandom_range(0, 65535));
        2: ofs = -$signed({16'd0, wide[31:0]});
        3: ofs = wide[OFFSET_BITS-1:0];
        4: ofs = OFS_MAX;
        5: ofs = OFS_MIN;
        6: ofs = -$signed({32'd0, wide[15:0]});
        default: ofs = wide[OFFSET_BITS-1:0];
      endcase
      write_offset(ofs);
      repeat (140) send_pixel(rand_pixel(offset_model));
    end
  endtask

  task automatic test_backpressure();
    write_offset(48'sd0);
    no_gaps = 1'b1;
    hold_req = HOLD_CYCLES;
    repeat (100) send_pixel(rand_pixel(offset_model));
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pixel = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_offset_q = '0;
    offset_model = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_pixels();
    test_directed_offsets();
    test_random_offsets();
    test_backpressure();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    while (pending_logs.size() != 0) begin
      void'(pending_logs.pop_front());
      report_mismatch("expected word never arrived");
    end
    $display("%0d pixels over %0d offset settings, %0d of them with a sum at or below zero",
             pixels_sent, offset_writes, invalid_sums);
    $display("input held off for %0d cycles by a full pipeline", in_held_cycles);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule
